>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, ignore cycles in reset.
`define ASSERT_ON_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check on every rising edge, reset cycles included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/es2dt_pkg.sv
package es2dt_pkg;

    // Input word
    localparam int EPOCH_W    = 32;
    localparam int MAG_W      = 31;

    // Intermediate counts (sized to what the divider stages can produce)
    localparam int MINS_W     = 26;
    localparam int HOURS_W    = 21;
    localparam int DAYS_W     = 17;
    localparam int ERA_DAYS_W = 18;
    localparam int QUAD_W     = 8;
    localparam int QREM_W     = 11;
    localparam int YOFF_W     = 2;
    localparam int DOY_W      = 9;

    // Result fields
    localparam int SEC_W      = 6;
    localparam int MIN_W      = 6;
    localparam int HOUR_W     = 5;
    localparam int DAY_W      = 5;
    localparam int MON_W      = 4;
    localparam int YEAR_W     = 11;

    localparam int SECS_PER_MIN   = 60;
    localparam int MINS_PER_HOUR  = 60;
    localparam int HOURS_PER_DAY  = 24;
    localparam int DAYS_PER_QUAD  = 1461;
    localparam int MONTHS         = 12;

    // Days are counted from 1968-01-01, the leap year that opens the
    // four-year cycle holding 1970-01-01.
    localparam int ERA_YEAR        = 1968;
    localparam int ERA_OFFSET_DAYS = 731;

    // First day of each year within a four-year cycle (first year is leap)
    localparam logic [QREM_W-1:0] QUAD_YEAR_START [0:3] = '{
        11'd0, 11'd366, 11'd731, 11'd1096
    };

    // Day of year (from 0) on which each month starts in a common year
    localparam logic [DOY_W-1:0] MONTH_FIRST [0:MONTHS-1] = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // Time of day carried alongside the date computation
    typedef struct packed {
        logic              bad;
        logic [SEC_W-1:0]  sec;
        logic [MIN_W-1:0]  minute;
        logic [HOUR_W-1:0] hour;
    } t_tod;

endpackage

>>> hw/rtl/es2dt_cdiv.sv
module es2dt_cdiv #(
    parameter int XW = 31,
    parameter int D  = 60,
    parameter int SW = 1,
    localparam int QW = $clog2(((64'd1 << XW) - 64'd1) / 64'(D) + 64'd1),
    localparam int RW = $clog2(D)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [XW-1:0] i_x,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [QW-1:0] o_q,
    output logic [RW-1:0] o_r,
    output logic [SW-1:0] o_side
);

    // Round-up reciprocal: exact quotient for every XW-bit dividend.
    localparam int K = XW + RW;
    localparam longint unsigned M = ((64'd1 << K) + 64'(D) - 64'd1) / 64'(D);
    localparam int MW = $clog2(M + 64'd1);
    localparam int PW = XW + MW;

    logic          r_a_vld;
    logic [XW-1:0] r_a_x;
    logic [SW-1:0] r_a_side;
    logic [PW-1:0] r_a_prod;

    logic          r_b_vld;
    logic [QW-1:0] r_b_q;
    logic [RW-1:0] r_b_r;
    logic [SW-1:0] r_b_side;

    logic          w_adv_a;
    logic          w_adv_b;
    logic [PW-1:0] w_shift;
    logic [QW-1:0] w_q;
    logic [XW-1:0] w_rem;

    assign w_adv_b = !r_b_vld || !i_stall;
    assign w_adv_a = !r_a_vld || w_adv_b;
    assign o_stall = !w_adv_a;

    assign w_shift = r_a_prod >> K;
    assign w_q     = w_shift[QW-1:0];
    assign w_rem   = r_a_x - XW'(w_q) * XW'(D);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (w_adv_a) begin
                r_a_vld <= i_valid;
            end
            if (w_adv_b) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_a && i_valid) begin
            r_a_x    <= i_x;
            r_a_side <= i_side;
            r_a_prod <= PW'(i_x) * PW'(M);
        end
        if (w_adv_b && r_a_vld) begin
            r_b_q    <= w_q;
            r_b_r    <= w_rem[RW-1:0];
            r_b_side <= r_a_side;
        end
    end

    assign o_valid = r_b_vld;
    assign o_q     = r_b_q;
    assign o_r     = r_b_r;
    assign o_side  = r_b_side;

endmodule

>>> hw/rtl/es2dt_date.sv
module es2dt_date (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [es2dt_pkg::QUAD_W-1:0] i_quad,
    input  logic [es2dt_pkg::QREM_W-1:0] i_qrem,
    input  es2dt_pkg::t_tod              i_tod,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [es2dt_pkg::YEAR_W-1:0] o_year,
    output logic [es2dt_pkg::MON_W-1:0]  o_month,
    output logic [es2dt_pkg::DAY_W-1:0]  o_day,
    output es2dt_pkg::t_tod              o_tod
);

    import es2dt_pkg::*;

    // Stage A: year within the four-year cycle and day of year
    logic              r_a_vld;
    logic [YEAR_W-1:0] r_a_year;
    logic [DOY_W-1:0]  r_a_doy;
    logic              r_a_leap;
    t_tod              r_a_tod;

    // Stage B: month and day of month
    logic              r_b_vld;
    logic [YEAR_W-1:0] r_b_year;
    logic [MON_W-1:0]  r_b_month;
    logic [DAY_W-1:0]  r_b_day;
    t_tod              r_b_tod;

    logic              w_adv_a;
    logic              w_adv_b;
    logic [YOFF_W-1:0] n_yoff;
    logic [QREM_W-1:0] n_ystart;
    logic [QREM_W-1:0] w_doy_full;
    logic [MON_W-1:0]  n_month;
    logic [DOY_W-1:0]  n_mstart;

    assign w_adv_b = !r_b_vld || !i_stall;
    assign w_adv_a = !r_a_vld || w_adv_b;
    assign o_stall = !w_adv_a;

    always_comb begin
        n_yoff   = '0;
        n_ystart = QUAD_YEAR_START[0];
        for (int k = 1; k < 4; k++) begin
            if (i_qrem >= QUAD_YEAR_START[k]) begin
                n_yoff   = YOFF_W'(k);
                n_ystart = QUAD_YEAR_START[k];
            end
        end
    end

    assign w_doy_full = i_qrem - n_ystart;

    // Months after February move by one day in a leap year.
    always_comb begin
        logic [DOY_W-1:0] first;
        n_month  = MON_W'(1);
        n_mstart = MONTH_FIRST[0];
        for (int k = 1; k < MONTHS; k++) begin
            first = MONTH_FIRST[k] + ((k >= 2) ? DOY_W'(r_a_leap) : '0);
            if (r_a_doy >= first) begin
                n_month  = MON_W'(k + 1);
                n_mstart = first;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (w_adv_a) begin
                r_a_vld <= i_valid;
            end
            if (w_adv_b) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_a && i_valid) begin
            r_a_year <= YEAR_W'(ERA_YEAR) + YEAR_W'({i_quad, n_yoff});
            r_a_doy  <= w_doy_full[DOY_W-1:0];
            r_a_leap <= (n_yoff == '0);
            r_a_tod  <= i_tod;
        end
        if (w_adv_b && r_a_vld) begin
            r_b_year  <= r_a_year;
            r_b_month <= n_month;
            r_b_day   <= DAY_W'(r_a_doy - n_mstart + DOY_W'(1));
            r_b_tod   <= r_a_tod;
        end
    end

    assign o_valid = r_b_vld;
    assign o_year  = r_b_year;
    assign o_month = r_b_month;
    assign o_day   = r_b_day;
    assign o_tod   = r_b_tod;

endmodule

>>> hw/rtl/epoch_seconds_to_date_time_top.sv
// Seconds-since-1970 to calendar date and time of day.
//
// Input channel: i_valid / o_stall carry one 32-bit signed word of seconds
// since 1970-01-01 00:00:00. A word is taken on a rising edge with i_valid
// high and o_stall low. A negative word yields o_bad_input = 1 with every
// other field zero.
// Output channel: o_valid / i_stall carry one result word per input word:
// second, minute, hour, day of month, month and year (1970 to 2038).
//
// The pipeline holds 11 register stages: four divide-by-constant units of two
// stages each (by 60, 60, 24 and by 1461 days per four-year cycle), two
// date stages and the output register. Throughput is one word per cycle
// while i_stall stays low; the multiplier in each divider stage sets the
// clock period.
// Each stage moves as soon as the one after it has room, so a stall at the
// output fills empty stages first and only then raises o_stall.
// Reset (i_rst_n low, synchronous) clears every valid bit; words in flight
// are dropped.
module epoch_seconds_to_date_time_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [es2dt_pkg::EPOCH_W-1:0] i_epoch_seconds,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_bad_input,
    output logic [es2dt_pkg::SEC_W-1:0]         o_second_of_minute,
    output logic [es2dt_pkg::MIN_W-1:0]         o_minute_of_hour,
    output logic [es2dt_pkg::HOUR_W-1:0]        o_hour_of_day,
    output logic [es2dt_pkg::DAY_W-1:0]         o_day_of_month,
    output logic [es2dt_pkg::MON_W-1:0]         o_month_of_year,
    output logic [es2dt_pkg::YEAR_W-1:0]        o_calendar_year
);

    import es2dt_pkg::*;

    // Seconds -> total minutes, second of minute
    logic                         w_s_vld;
    logic                         w_s_stall;
    logic [MINS_W-1:0]            w_mins;
    logic [SEC_W-1:0]             w_sec;
    logic                         w_s_bad;

    // Minutes -> total hours, minute of hour
    logic                         w_m_vld;
    logic                         w_m_stall;
    logic [HOURS_W-1:0]           w_hours;
    logic [MIN_W-1:0]             w_min;
    logic [SEC_W:0]               w_m_side;

    // Hours -> days since 1970, hour of day
    logic                         w_h_vld;
    logic                         w_h_stall;
    logic [DAYS_W-1:0]            w_days;
    logic [HOUR_W-1:0]            w_hour;
    logic [SEC_W+MIN_W:0]         w_h_side;
    logic [ERA_DAYS_W-1:0]        w_era_days;
    t_tod                         w_h_tod;

    // Days since 1968 -> four-year cycle and day within it
    logic                         w_q_vld;
    logic                         w_q_stall;
    logic [QUAD_W-1:0]            w_quad;
    logic [QREM_W-1:0]            w_qrem;
    t_tod                         w_q_tod;

    // Date
    logic                         w_d_vld;
    logic                         w_d_stall;
    logic [YEAR_W-1:0]            w_year;
    logic [MON_W-1:0]             w_month;
    logic [DAY_W-1:0]             w_day;
    t_tod                         w_d_tod;

    // Output register
    logic                         r_o_vld;
    logic                         r_o_bad;
    logic [SEC_W-1:0]             r_o_sec;
    logic [MIN_W-1:0]             r_o_min;
    logic [HOUR_W-1:0]            r_o_hour;
    logic [DAY_W-1:0]             r_o_day;
    logic [MON_W-1:0]             r_o_month;
    logic [YEAR_W-1:0]            r_o_year;
    logic                         w_adv_o;

    // The sign bit rides along as the error flag; the low bits are
    // converted anyway and zeroed at the output.
    es2dt_cdiv #(
        .XW (MAG_W),
        .D  (SECS_PER_MIN),
        .SW (1)
    ) u_div_sec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_x     (i_epoch_seconds[MAG_W-1:0]),
        .i_side  (i_epoch_seconds[EPOCH_W-1]),
        .o_valid (w_s_vld),
        .i_stall (w_s_stall),
        .o_q     (w_mins),
        .o_r     (w_sec),
        .o_side  (w_s_bad)
    );

    es2dt_cdiv #(
        .XW (MINS_W),
        .D  (MINS_PER_HOUR),
        .SW (SEC_W + 1)
    ) u_div_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s_vld),
        .o_stall (w_s_stall),
        .i_x     (w_mins),
        .i_side  ({w_s_bad, w_sec}),
        .o_valid (w_m_vld),
        .i_stall (w_m_stall),
        .o_q     (w_hours),
        .o_r     (w_min),
        .o_side  (w_m_side)
    );

    es2dt_cdiv #(
        .XW (HOURS_W),
        .D  (HOURS_PER_DAY),
        .SW (SEC_W + MIN_W + 1)
    ) u_div_hour (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_m_vld),
        .o_stall (w_m_stall),
        .i_x     (w_hours),
        .i_side  ({w_m_side, w_min}),
        .o_valid (w_h_vld),
        .i_stall (w_h_stall),
        .o_q     (w_days),
        .o_r     (w_hour),
        .o_side  (w_h_side)
    );

    // Rebase the day count to 1968-01-01 so each cycle opens on a leap
    // year. Every fourth year is leap from 1968 through 2038: 2000 keeps
    // its leap day under the 400-year rule and 2100 is out of reach.
    assign w_era_days = ERA_DAYS_W'(w_days) + ERA_DAYS_W'(ERA_OFFSET_DAYS);
    assign w_h_tod    = {w_h_side, w_hour};

    es2dt_cdiv #(
        .XW ($bits(w_era_days)),
        .D  (DAYS_PER_QUAD),
        .SW ($bits(t_tod))
    ) u_div_quad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_h_vld),
        .o_stall (w_h_stall),
        .i_x     (w_era_days),
        .i_side  (w_h_tod),
        .o_valid (w_q_vld),
        .i_stall (w_q_stall),
        .o_q     (w_quad),
        .o_r     (w_qrem),
        .o_side  (w_q_tod)
    );

    es2dt_date u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_vld),
        .o_stall (w_q_stall),
        .i_quad  (w_quad),
        .i_qrem  (w_qrem),
        .i_tod   (w_q_tod),
        .o_valid (w_d_vld),
        .i_stall (w_d_stall),
        .o_year  (w_year),
        .o_month (w_month),
        .o_day   (w_day),
        .o_tod   (w_d_tod)
    );

    // Output register: hold while the receiver stalls, take the next word
    // whenever it is empty or being drained.
    assign w_adv_o   = !r_o_vld || !i_stall;
    assign w_d_stall = !w_adv_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_adv_o) begin
            r_o_vld <= w_d_vld;
        end
    end

    // Negative input: flag it and clear every other field.
    always_ff @(posedge i_clk) begin
        if (w_adv_o && w_d_vld) begin
            r_o_bad <= w_d_tod.bad;
            if (w_d_tod.bad) begin
                r_o_sec   <= '0;
                r_o_min   <= '0;
                r_o_hour  <= '0;
                r_o_day   <= '0;
                r_o_month <= '0;
                r_o_year  <= '0;
            end else begin
                r_o_sec   <= w_d_tod.sec;
                r_o_min   <= w_d_tod.minute;
                r_o_hour  <= w_d_tod.hour;
                r_o_day   <= w_day;
                r_o_month <= w_month;
                r_o_year  <= w_year;
            end
        end
    end

    assign o_valid            = r_o_vld;
    assign o_bad_input        = r_o_bad;
    assign o_second_of_minute = r_o_sec;
    assign o_minute_of_hour   = r_o_min;
    assign o_hour_of_day      = r_o_hour;
    assign o_day_of_month     = r_o_day;
    assign o_month_of_year    = r_o_month;
    assign o_calendar_year    = r_o_year;

endmodule

>>> hw/rtl/es2dt_checker.sv
`include "assert_macros.svh"

module es2dt_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         o_stall,
    input  logic                         o_valid,
    input  logic                         i_stall,
    input  logic                         o_bad_input,
    input  logic [es2dt_pkg::SEC_W-1:0]  o_second_of_minute,
    input  logic [es2dt_pkg::MIN_W-1:0]  o_minute_of_hour,
    input  logic [es2dt_pkg::HOUR_W-1:0] o_hour_of_day,
    input  logic [es2dt_pkg::DAY_W-1:0]  o_day_of_month,
    input  logic [es2dt_pkg::MON_W-1:0]  o_month_of_year,
    input  logic [es2dt_pkg::YEAR_W-1:0] o_calendar_year
);

    import es2dt_pkg::*;

    `ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_valid, "valid after reset")

    `ASSERT_ON_CLK(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid, "word dropped")

    `ASSERT_ON_CLK(a_stall_only_full, i_clk, i_rst_n, o_stall |-> o_valid && i_stall, "stall with room")

    `ASSERT_ON_CLK(a_bad_zero, i_clk, i_rst_n, o_valid && o_bad_input |-> o_second_of_minute == 0 && o_minute_of_hour == 0 && o_hour_of_day == 0 && o_day_of_month == 0 && o_month_of_year == 0 && o_calendar_year == 0, "error word not cleared")

    `ASSERT_ON_CLK(a_good_range, i_clk, i_rst_n, o_valid && !o_bad_input |-> o_second_of_minute <= 59 && o_minute_of_hour <= 59 && o_hour_of_day <= 23 && o_day_of_month >= 1 && o_day_of_month <= 31 && o_month_of_year >= 1 && o_month_of_year <= 12 && o_calendar_year >= 1970 && o_calendar_year <= 2038, "field out of range")

endmodule

bind epoch_seconds_to_date_time_top es2dt_checker u_es2dt_checker (.*);
